// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bdq_pkg.sv -----
`default_nettype none

package bdq_pkg;

    localparam int FUNC_W     = 2;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_LOOKUP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_deque_with_search.sv -----
`default_nettype none

// Bounded double-ended queue of DEPTH values held in a ring in one RAM. Each input
// item carries an operation in s_tuser (insert front, insert back, remove back,
// lookup) and a value in s_tdata; each yields one result item with found, entry
// count, empty flag and status. An insert or removal goes from acceptance to the done
// state, where it is written to the result register once the output register is free;
// the next item is taken after that. A lookup first walks the held entries through the
// single RAM read port, one entry per cycle, and then goes to the done state likewise.
// s_tready is high whenever no item is in work; a finished result waits in the
// output register without blocking acceptance of the next item, but that item's
// result stays in work, with s_tready low, until the output register is taken.
// Inserts into a full store and removals from an empty one leave it unchanged
// and are flagged in status.

module bounded_deque_with_search #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int OUT_BITS   = 1 + CNT_W + 1 + bdq_pkg::STATUS_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bdq_pkg::VALUE_IN_W-1:0]  s_tdata,   // value
    input  wire logic [bdq_pkg::FUNC_W-1:0]      s_tuser,   // func
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [OUT_W-1:0]                m_tdata    // found, count, is_empty, status
);

    localparam int PW   = $clog2(DEPTH);
    localparam int IN_W = (VALUE_WIDTH < bdq_pkg::VALUE_IN_W) ? VALUE_WIDTH
                                                               : bdq_pkg::VALUE_IN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [PW-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    bdq_pkg::status_t      status_reg, status_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [PW-1:0]         addr_reg, addr_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  pend_reg, pend_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    logic [VALUE_WIDTH-1:0] key_in;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [PW-1:0]          front_dec;
    logic [PW-1:0]          addr_inc;
    logic [CNT_W:0]         back_sum;
    logic [PW-1:0]          back_idx;
    logic                   full;
    logic                   empty;
    logic                   accept;
    logic                   hit;
    logic                   ram_we;
    logic [PW-1:0]          ram_waddr;
    logic                   ram_re;
    bdq_pkg::op_t           op;

    assign key_in    = VALUE_WIDTH'(s_tdata[IN_W-1:0]);
    assign op        = bdq_pkg::op_t'(s_tuser);
    assign s_tready  = aresetn && (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign addr_inc  = (addr_reg == PW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign back_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign back_idx  = (back_sum >= (CNT_W + 1)'(DEPTH))
                       ? PW'(back_sum - (CNT_W + 1)'(DEPTH)) : PW'(back_sum);
    assign hit       = pend_reg && (rd_data == key_reg);

    assign ram_we    = accept && !full
                       && (op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_BACK);
    assign ram_waddr = (op == bdq_pkg::OP_PUSH_FRONT) ? front_dec : back_idx;
    assign ram_re    = (state_reg == S_SCAN) && (scan_reg != count_reg);

    bdq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_bdq_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_in),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next    = key_in;
                    found_next  = 1'b0;
                    status_next = bdq_pkg::ST_OK;
                    state_next  = S_DONE;
                    case (op)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                status_next = bdq_pkg::ST_FULL;
                            end else begin
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                status_next = bdq_pkg::ST_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                status_next = bdq_pkg::ST_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::OP_LOOKUP: begin
                            addr_next  = front_reg;
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                found_next = found_reg || hit;
                if (scan_reg != count_reg) begin
                    pend_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                    addr_next = addr_inc;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({status_reg, empty, count_reg, found_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            status_reg   <= bdq_pkg::ST_OK;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg     <= key_next;
        addr_reg    <= addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bdq_ram.sv -----
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bdq_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module bdq_checker #(
    parameter int DEPTH   = 16,
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int OUT_BITS = 1 + CNT_W + 1 + bdq_pkg::STATUS_W,
    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    logic                          found;
    logic [CNT_W-1:0]              cnt;
    logic                          is_empty;
    logic [bdq_pkg::STATUS_W-1:0]  sts;

    assign found    = m_tdata[0];
    assign cnt      = m_tdata[CNT_W:1];
    assign is_empty = m_tdata[CNT_W+1];
    assign sts      = m_tdata[CNT_W+3:CNT_W+2];

    `ASSERT_NEXT(a_valid_held, m_tvalid && !m_tready, m_tvalid, "stalled result item dropped")

    `ASSERT_SAME(a_empty_flag, m_tvalid, is_empty == (cnt == '0), "empty flag disagrees with count")

    `ASSERT_SAME(a_full_status, m_tvalid && (sts == bdq_pkg::ST_FULL), cnt == CNT_W'(DEPTH), "full status below capacity")

    `ASSERT_SAME(a_empty_status, m_tvalid && (sts == bdq_pkg::ST_EMPTY), cnt == '0, "empty status with entries held")

    `ASSERT_HOLDS(a_found_ok, !(m_tvalid && found) || (sts == bdq_pkg::ST_OK && cnt != '0), "found without held entries")

endmodule

bind bounded_deque_with_search bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_bounded_deque_with_search.sv -----
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;

    localparam int DEPTH     = 16;
    localparam int VAL_W     = 32;
    localparam int OUT_W     = 16;
    localparam int N_ITEMS   = 1650;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        bdq_pkg::status_t status;
        logic             is_empty;
        logic [4:0]       count;
        logic             found;
    } deque_result_t;

    class deque_tracker;
        logic [VAL_W-1:0] ring [DEPTH];
        logic [3:0]       head;
        int unsigned      held;
        deque_result_t    pending[$];
        int               errors;

        function new();
            head   = '0;
            held   = 0;
            errors = 0;
        endfunction

        // Applies one accepted item to the shadow deque and queues its result.
        function void apply_op(bdq_pkg::op_t op, logic [VAL_W-1:0] v);
            deque_result_t r;
            logic [3:0]    idx;
            r = '0;
            r.status = bdq_pkg::ST_OK;
            case (op)
                bdq_pkg::OP_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = bdq_pkg::ST_FULL;
                    end else begin
                        head = head - 4'd1;
                        ring[head] = v;
                        held++;
                    end
                end
                bdq_pkg::OP_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = bdq_pkg::ST_FULL;
                    end else begin
                        idx = head + 4'(held);
                        ring[idx] = v;
                        held++;
                    end
                end
                bdq_pkg::OP_POP_BACK: begin
                    if (held == 0) begin
                        r.status = bdq_pkg::ST_EMPTY;
                    end else begin
                        held--;
                    end
                end
                default: begin
                    for (int k = 0; k < held; k++) begin
                        idx = head + 4'(k);
                        if (ring[idx] == v) begin
                            r.found = 1'b1;
                        end
                    end
                end
            endcase
            r.count    = 5'(held);
            r.is_empty = (held == 0);
            pending.insert(pending.size(), r);
        endfunction

        function logic [VAL_W-1:0] pick_held();
            logic [3:0] idx;
            idx = head + 4'($urandom_range(0, held - 1));
            return ring[idx];
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            deque_result_t got, want;
            got = data[8:0];
            if (pending.size() == 0) begin
                if (errors < MAX_SHOWN) begin
                    $display("unexpected result item: found=%0b count=%0d empty=%0b status=%0d",
                             got.found, got.count, got.is_empty, got.status);
                end
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.found !== want.found || got.count !== want.count ||
                    got.is_empty !== want.is_empty || got.status !== want.status) begin
                    if (errors < MAX_SHOWN) begin
                        $display("mismatch: exp found=%0b count=%0d empty=%0b status=%0d, %s",
                                 want.found, want.count, want.is_empty, want.status,
                                 $sformatf("got found=%0b count=%0d empty=%0b status=%0d",
                                           got.found, got.count, got.is_empty, got.status));
                    end
                    errors++;
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    deque_tracker book = new();
    int  n_sent;
    bit  tx_steady;
    bit  rx_steady;

    bounded_deque_with_search #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VAL_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return VAL_W'($signed($urandom_range(0, 7)) - 4);
        end else if (r < 35) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_item(bdq_pkg::op_t op, logic [VAL_W-1:0] v);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        book.apply_op(op, v);
        n_sent++;
        @(negedge aclk);
    endtask

    // result side: random stalls, with steady stretches
    initial begin
        int gap;
        int left;
        left = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (left == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
                left = $urandom_range(20, 80);
            end
            left--;
            gap = rx_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            book.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin
        int mode, seg_len, r;
        bdq_pkg::op_t op;
        logic [VAL_W-1:0] v;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        n_sent    = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty-store corner cases, value extremes, hits and misses
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_LOOKUP, 32'h0000_0000);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(bdq_pkg::OP_LOOKUP, 32'h8000_0000);
        send_item(bdq_pkg::OP_LOOKUP, 32'h7FFF_FFFF);
        send_item(bdq_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        send_item(bdq_pkg::OP_LOOKUP, 32'h0000_0005);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_LOOKUP, 32'h8000_0000);

        // random: segments biased to fill, drain or churn the deque
        while (n_sent < N_ITEMS) begin
            mode      = $urandom_range(0, 2);
            seg_len   = $urandom_range(10, 60);
            tx_steady = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: op = (r < 35) ? bdq_pkg::OP_PUSH_FRONT :
                            (r < 70) ? bdq_pkg::OP_PUSH_BACK :
                            (r < 82) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_LOOKUP;
                    1: op = (r < 12) ? bdq_pkg::OP_PUSH_FRONT :
                            (r < 24) ? bdq_pkg::OP_PUSH_BACK :
                            (r < 70) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_LOOKUP;
                    default: op = bdq_pkg::op_t'(r % 4);
                endcase
                if (op == bdq_pkg::OP_LOOKUP && book.held > 0 && $urandom_range(0, 1))
                    v = book.pick_held();
                else
                    v = rand_value();
                send_item(op, v);
            end
        end
        s_tvalid <= 1'b0;

        while (book.pending.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
